// ----- sv/stpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_pkg: shared types and constants for the ticket priority queue
// Field widths, request and status codes, level limits and sequencer states.
// ----------------------------------------------------------------------------
package stpq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int REQ_W    = 2;
	localparam int PRIO_W   = 3;
	localparam int STATUS_W = 2;
	localparam int TICKET_W = 16;
	localparam int LEVEL_W  = 3;
	localparam int ENTRY_W  = TICKET_W + LEVEL_W;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 24;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENTER = 2'd0,
		REQ_SERVE = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_LIST  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_INVALID = 2'd3
	} status_t;

	localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 3'd5;
	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 3'd7;

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_EXEC      = 9'b000000010,
		S_SCAN_RD   = 9'b000000100,
		S_SCAN_CHK  = 9'b000001000,
		S_EMIT_BEST = 9'b000010000,
		S_SHIFT_RD  = 9'b000100000,
		S_SHIFT_WR  = 9'b001000000,
		S_LIST_RD   = 9'b010000000,
		S_LIST_CHK  = 9'b100000000
	} state_t;

endpackage : stpq_pkg
`default_nettype wire

// ----- sv/stable_ticket_priority_queue_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_ticket_priority_queue_unit: bounded stable priority queue of tickets
// Enter, serve, peek and list requests over entries kept in arrival order in
// one RAM, walked by a small sequencer with one read and one write port.
// Enter and error requests load their result in S_EXEC once the output is free;
//   serve and peek scan every entry (S_SCAN_RD, S_SCAN_CHK) before S_EMIT_BEST,
//   serve then closes the gap, S_SHIFT_RD then S_SHIFT_WR for each entry behind it.
// List: one pass per level reads every entry, up to 5 passes, one result per hit.
// Throughput: one request at a time; the RAM port and scan loop set the rate.
// Reset: occupancy 0, next ticket 1; stored entries are not cleared.
// ----------------------------------------------------------------------------
module stable_ticket_priority_queue_unit #(
	parameter int CAPACITY = stpq_pkg::CAPACITY_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [stpq_pkg::S_TDATA_W-1:0] s_tdata,  // [2:0] priority_req
	input  wire logic [stpq_pkg::REQ_W-1:0]     s_tuser,  // [1:0] req_type
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [stpq_pkg::M_TDATA_W-1:0] m_tdata,  // [15:0] ticket, [18:16] level
	output logic      [stpq_pkg::STATUS_W-1:0]  m_tuser,  // [1:0] status
	output logic                                m_tlast
);

	import stpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);

	state_t                state_q, state_d;
	logic [REQ_W-1:0]      req_q;
	logic [PRIO_W-1:0]     prio_q;
	logic [OW-1:0]         occ_q;
	logic [OW-1:0]         cnt_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         best_q;
	logic [LEVEL_W-1:0]    best_lv_q;
	logic [TICKET_W-1:0]   best_tk_q;
	logic [LEVEL_W-1:0]    lv_q;
	logic [TICKET_W-1:0]   next_tk_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [TICKET_W-1:0]   out_ticket_q;
	logic [LEVEL_W-1:0]    out_level_q;
	logic                  out_last_q;

	logic                  load;
	logic [STATUS_W-1:0]   ld_status;
	logic [TICKET_W-1:0]   ld_ticket;
	logic [LEVEL_W-1:0]    ld_level;
	logic                  ld_last;

	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [ENTRY_W-1:0]    wr_data, rd_data;
	logic [TICKET_W-1:0]   rd_ticket;
	logic [LEVEL_W-1:0]    rd_level;

	logic                  slot_free;
	logic [OW-1:0]         occ_m1;
	logic                  idx_at_end;
	logic                  is_full;
	logic                  prio_ok;
	logic                  list_hit;
	logic                  list_last;

	assign s_tready   = (state_q == S_IDLE);
	assign slot_free  = !out_valid_q || m_tready;
	assign occ_m1     = occ_q - OW'(1);
	assign idx_at_end = (OW'(idx_q) == occ_m1);
	assign is_full    = (occ_q == OW'(CAPACITY));
	assign prio_ok    = (prio_q >= LEVEL_MIN) && (prio_q <= LEVEL_MAX);
	assign rd_ticket  = rd_data[TICKET_W-1:0];
	assign rd_level   = rd_data[ENTRY_W-1:TICKET_W];
	assign list_hit   = (rd_level == lv_q);
	assign list_last  = (cnt_q == occ_m1);

	stpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		ld_status = STAT_OK;
		ld_ticket = '0;
		ld_level  = '0;
		ld_last   = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = rd_data;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (req_q == REQ_ENTER) begin
					if (slot_free) begin
						load    = 1'b1;
						state_d = S_IDLE;
						if (is_full) begin
							ld_status = STAT_FULL;
						end else if (!prio_ok) begin
							ld_status = STAT_INVALID;
						end else begin
							ld_ticket = next_tk_q;
							ld_level  = prio_q;
							wr_en     = 1'b1;
							wr_addr   = occ_q[AW-1:0];
							wr_data   = {prio_q, next_tk_q};
						end
					end
				end else if (occ_q == '0) begin
					if (slot_free) begin
						load      = 1'b1;
						ld_status = STAT_EMPTY;
						state_d   = S_IDLE;
					end
				end else if (req_q == REQ_LIST) begin
					state_d = S_LIST_RD;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				rd_en   = 1'b1;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_d = idx_at_end ? S_EMIT_BEST : S_SCAN_RD;
			end
			S_EMIT_BEST: begin
				if (slot_free) begin
					load      = 1'b1;
					ld_ticket = best_tk_q;
					ld_level  = best_lv_q;
					if (req_q == REQ_SERVE && OW'(best_q) != occ_m1) begin
						state_d = S_SHIFT_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q + AW'(1);
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				state_d = (OW'(idx_q) + OW'(1) == occ_m1) ? S_IDLE : S_SHIFT_RD;
			end
			S_LIST_RD: begin
				rd_en   = 1'b1;
				state_d = S_LIST_CHK;
			end
			S_LIST_CHK: begin
				if (!list_hit) begin
					state_d = S_LIST_RD;
				end else if (slot_free) begin
					load      = 1'b1;
					ld_ticket = rd_ticket;
					ld_level  = rd_level;
					ld_last   = list_last;
					state_d   = list_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			next_tk_q <= TICKET_W'(1);
			cnt_q     <= '0;
			idx_q     <= '0;
			best_q    <= '0;
			best_lv_q <= LEVEL_NONE;
			best_tk_q <= '0;
			lv_q      <= LEVEL_MIN;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_EXEC: begin
					idx_q     <= '0;
					best_q    <= '0;
					best_lv_q <= LEVEL_NONE;
					cnt_q     <= '0;
					lv_q      <= LEVEL_MIN;
					if (wr_en) begin
						occ_q     <= occ_q + OW'(1);
						next_tk_q <= next_tk_q + TICKET_W'(1);
					end
				end
				S_SCAN_CHK: begin
					if (rd_level < best_lv_q) begin
						best_q    <= idx_q;
						best_lv_q <= rd_level;
						best_tk_q <= rd_ticket;
					end
					if (!idx_at_end) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_EMIT_BEST: begin
					idx_q <= best_q;
					if (slot_free && req_q == REQ_SERVE && OW'(best_q) == occ_m1) begin
						occ_q <= occ_m1;
					end
				end
				S_SHIFT_WR: begin
					idx_q <= idx_q + AW'(1);
					if (state_d == S_IDLE) begin
						occ_q <= occ_m1;
					end
				end
				S_LIST_CHK: begin
					if (!list_hit || slot_free) begin
						if (list_hit) begin
							cnt_q <= cnt_q + OW'(1);
						end
						if (idx_at_end) begin
							idx_q <= '0;
							lv_q  <= lv_q + LEVEL_W'(1);
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= s_tuser;
			prio_q <= s_tdata[PRIO_W-1:0];
		end
		if (load) begin
			out_status_q <= ld_status;
			out_ticket_q <= ld_ticket;
			out_level_q  <= ld_level;
			out_last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_TDATA_W - TICKET_W - LEVEL_W){1'b0}}, out_level_q, out_ticket_q};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(CAPACITY))
		else $error("occupancy above capacity");

	a_list_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST_CHK) |-> (cnt_q < occ_q))
		else $error("list emitted more entries than stored");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ld_status != STAT_OK) |-> ld_last)
		else $error("error result not marked last");

	a_enter_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && wr_en) |=> (occ_q == $past(occ_q) + OW'(1)))
		else $error("enter did not add an entry");

endmodule : stable_ticket_priority_queue_unit
`default_nettype wire

// ----- sv/stpq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stpq_ram: generic single-write, single-read RAM
// One write port, one read port with registered data held while rd_en is low.
// ----------------------------------------------------------------------------
module stpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : stpq_ram
`default_nettype wire

// ----- bench/stable_ticket_priority_queue_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_ticket_priority_queue_unit_test: self-checking bench for the queue
// Sends enter, serve, peek and list transactions over the request stream. A
// scoreboard keeps its own copy of the queue and checks every result of the
// block in order. The run covers empty, full and invalid requests, stable
// ordering and full taking precedence over a bad level. Idle bursts are applied
// on both sides, plus one long stall on the output side.
// ----------------------------------------------------------------------------
module stable_ticket_priority_queue_unit_test;
	import stpq_pkg::*;

	localparam int QUEUE_DEPTH = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 120;
	localparam int QUIET_ITEMS = 30;
	localparam int HOLD_AT_ITEM = 40;
	localparam int LONG_HOLD = 400;
	localparam int END_DRAIN = 200;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TICKET_W-1:0] ticket;
		logic [LEVEL_W-1:0]  level;
		logic                last;
	} result_t;

	class queue_scoreboard;
		logic [TICKET_W-1:0] slot_ticket [QUEUE_DEPTH];
		logic [LEVEL_W-1:0]  slot_level [QUEUE_DEPTH];
		int                  occupancy;
		int                  peak_occupancy;
		logic [TICKET_W-1:0] next_ticket;
		result_t             expected_q[$];
		int                  requests;
		int                  checked;
		int                  mismatches;
		int                  lists;
		int                  fulls;
		int                  empties;
		int                  invalids;
		bit                  wrapped;

		function new();
			occupancy = 0;
			peak_occupancy = 0;
			next_ticket = 1;
			requests = 0;
			checked = 0;
			mismatches = 0;
			lists = 0;
			fulls = 0;
			empties = 0;
			invalids = 0;
			wrapped = 1'b0;
		endfunction

		function void push_result(status_t status, logic [TICKET_W-1:0] ticket,
				logic [LEVEL_W-1:0] level, logic last);
			result_t r;
			r.status = status;
			r.ticket = ticket;
			r.level = level;
			r.last = last;
			expected_q.push_back(r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(req_t req, logic [PRIO_W-1:0] prio);
			int best;
			requests++;
			if (req == REQ_ENTER) begin
				if (occupancy >= QUEUE_DEPTH) begin
					fulls++;
					push_result(STAT_FULL, '0, '0, 1'b1);
				end else if (prio < LEVEL_MIN || prio > LEVEL_MAX) begin
					invalids++;
					push_result(STAT_INVALID, '0, '0, 1'b1);
				end else begin
					slot_ticket[occupancy] = next_ticket;
					slot_level[occupancy] = prio;
					occupancy++;
					if (occupancy > peak_occupancy)
						peak_occupancy = occupancy;
					if (next_ticket == '0)
						wrapped = 1'b1;
					push_result(STAT_OK, next_ticket, prio, 1'b1);
					next_ticket++;
				end
			end else if (occupancy == 0) begin
				empties++;
				push_result(STAT_EMPTY, '0, '0, 1'b1);
			end else if (req == REQ_LIST) begin
				lists++;
				for (int lv = LEVEL_MIN; lv <= LEVEL_MAX; lv++)
					for (int i = 0; i < occupancy; i++)
						if (slot_level[i] == lv)
							push_result(STAT_OK, slot_ticket[i], slot_level[i], 1'b0);
				expected_q[expected_q.size() - 1].last = 1'b1;
			end else begin
				// earliest arrival wins among equal levels
				best = 0;
				for (int i = 1; i < occupancy; i++)
					if (slot_level[i] < slot_level[best])
						best = i;
				push_result(STAT_OK, slot_ticket[best], slot_level[best], 1'b1);
				if (req == REQ_SERVE) begin
					for (int i = best; i + 1 < occupancy; i++) begin
						slot_ticket[i] = slot_ticket[i + 1];
						slot_level[i] = slot_level[i + 1];
					end
					occupancy--;
				end
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [TICKET_W-1:0] ticket,
				logic [LEVEL_W-1:0] level, logic last);
			result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d ticket %0d level %0d last %0b",
						status, ticket, level, last);
				return;
			end
			want = expected_q.pop_front();
			if (status !== want.status || ticket !== want.ticket ||
					level !== want.level || last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: expected status %0d ticket %0d level %0d last %0b",
						checked, want.status, want.ticket, want.level, want.last);
					$display("result %0d:      got status %0d ticket %0d level %0d last %0b",
						checked, status, ticket, level, last);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // [2:0] priority_req
	logic [REQ_W-1:0]     s_tuser = '0;   // [1:0] req_type
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [15:0] ticket, [18:16] level
	logic [STATUS_W-1:0]  m_tuser;        // [1:0] status
	logic                 m_tlast;

	queue_scoreboard sb;
	bit              idle_en = 1'b0;
	int              hold_requests = 0;
	longint          cycle_count = 0;

	stable_ticket_priority_queue_unit #(
		.CAPACITY(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (s_tvalid && s_tready)
				sb.note_request(req_t'(s_tuser), s_tdata[PRIO_W-1:0]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata[TICKET_W-1:0],
					m_tdata[TICKET_W +: LEVEL_W], m_tlast);
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("FAIL stable_ticket_priority_queue_unit");
				$finish;
			end
		end
	end

	// result side: random idle bursts, plus a long hold on request
	initial begin
		int burst_left;
		int hold_left;
		int holds_seen;
		burst_left = 0;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(negedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 7) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [PRIO_W-1:0] valid_level();
		return PRIO_W'($urandom_range(LEVEL_MIN, LEVEL_MAX));
	endfunction

	function automatic logic [PRIO_W-1:0] invalid_level();
		case ($urandom_range(0, 2))
			0: return 3'd0;
			1: return 3'd6;
			default: return 3'd7;
		endcase
	endfunction

	function automatic logic [PRIO_W-1:0] any_level();
		return PRIO_W'($urandom_range(0, 7));
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_request(req_t req, logic [PRIO_W-1:0] prio);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= S_TDATA_W'(prio);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_request(bit filling);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < (filling ? 50 : 20))
			send_request(REQ_ENTER, valid_level());
		else if (pick < (filling ? 58 : 26))
			send_request(REQ_ENTER, invalid_level());
		else if (pick < (filling ? 72 : 70))
			send_request(REQ_SERVE, any_level());
		else if (pick < 86)
			send_request(REQ_PEEK, any_level());
		else
			send_request(REQ_LIST, any_level());
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_en = 1'b1;

		// empty queue and bad levels
		send_request(REQ_SERVE, 3'd0);
		send_request(REQ_PEEK, 3'd7);
		send_request(REQ_LIST, 3'd3);
		send_request(REQ_ENTER, 3'd0);
		send_request(REQ_ENTER, 3'd7);

		// repeated levels to check arrival order is kept
		send_request(REQ_ENTER, 3'd5);
		send_request(REQ_ENTER, 3'd1);
		send_request(REQ_ENTER, 3'd3);
		send_request(REQ_ENTER, 3'd1);
		send_request(REQ_ENTER, 3'd3);
		send_request(REQ_ENTER, 3'd2);
		send_request(REQ_ENTER, 3'd4);
		send_request(REQ_ENTER, 3'd5);
		send_request(REQ_PEEK, 3'd2);
		send_request(REQ_LIST, 3'd5);
		send_request(REQ_SERVE, 3'd1);

		// full queue; full takes precedence over a bad level
		while (sb.occupancy < QUEUE_DEPTH)
			send_request(REQ_ENTER, valid_level());
		send_request(REQ_ENTER, 3'd3);
		send_request(REQ_ENTER, 3'd0);
		send_request(REQ_LIST, 3'd6);
		send_request(REQ_SERVE, 3'd4);

		// drain, then refill part way back to back
		idle_en = 1'b0;
		while (sb.occupancy > 0)
			send_request(REQ_SERVE, any_level());
		repeat (12)
			send_request(REQ_ENTER, valid_level());
		send_request(REQ_LIST, any_level());
		send_request(REQ_PEEK, any_level());
		send_request(REQ_SERVE, any_level());

		idle_en = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT_ITEM)
				hold_requests++;
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				idle_en = 1'b0;
			random_request((i / 30) % 2 == 0);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);

		$display("%0d requests, %0d results: %0d lists, %0d full, %0d empty, %0d invalid",
			sb.requests, sb.checked, sb.lists, sb.fulls, sb.empties, sb.invalids);
		$display("peak occupancy %0d, ticket wrap %s, %0d mismatches, %0d left over",
			sb.peak_occupancy, sb.wrapped ? "reached" : "not reached",
			sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS stable_ticket_priority_queue_unit");
		else
			$display("FAIL stable_ticket_priority_queue_unit");
		$finish;
	end

endmodule : stable_ticket_priority_queue_unit_test

// ----- files.f -----
sv/stpq_pkg.sv
sv/stpq_ram.sv
sv/stable_ticket_priority_queue_unit.sv
bench/stable_ticket_priority_queue_unit_test.sv
